>>> hw/rtl/smr_pkg.sv
package smr_pkg;

   localparam int ADDR_W   = 44;
   localparam int EXT_W    = ADDR_W + 1;
   localparam int DATA_W   = 64;
   localparam int KIND_W   = 3;
   localparam int CPU_W    = 2;
   localparam int SIZE_W   = 2;
   localparam int RLEN_W   = 7;
   localparam int STATUS_W = 3;
   localparam int LOST_W   = 4;
   localparam int LIMIT_W  = 17;
   localparam int OWNER_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALIGN   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADADDR = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CPU_W-1:0]  cpu;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size_code;
      logic [DATA_W-1:0] write_data;
      logic [RLEN_W-1:0] res_size;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
      logic                reserved;
      logic [LOST_W-1:0]   lost_mask;
   } rsp_type;

   // Answer of the reservation monitor for the item being executed.
   typedef struct packed {
      logic              reserved;
      logic              table_full;
      logic [LOST_W-1:0] lost_mask;
   } mon_rsp_type;

   // Number of bytes of an access, 1 << size_code.
   function automatic logic [3:0] access_bytes(input logic [SIZE_W-1:0] size_code);
      return 4'd1 << size_code;
   endfunction

endpackage

>>> hw/rtl/smr_if.sv
interface smr_req_if;
   import smr_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface smr_rsp_if;
   import smr_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/smr_mem.sv
module smr_mem #(
   parameter int WORDS = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [$clog2(WORDS)-1:0]  rd_index,
   output logic [smr_pkg::DATA_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(WORDS)-1:0]  wr_index,
   input  logic [smr_pkg::DATA_W-1:0] wr_data,
   output logic                      clearing
);
   import smr_pkg::*;

   localparam int IW = $clog2(WORDS);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [IW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              port_we;
   logic [IW-1:0]     port_addr;
   logic [DATA_W-1:0] port_data;

   // After reset every word is swept to zero, one word per cycle.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + IW'(1);
         if (clr_cnt_ff == IW'(WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign port_we   = clr_busy_ff || wr_en;
   assign port_addr = clr_busy_ff ? clr_cnt_ff : wr_index;
   assign port_data = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

>>> hw/rtl/smr_monitor.sv
module smr_monitor #(
   parameter int CPUS          = 4,
   parameter int SLOTS_PER_CPU = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 write_ok,
   input  smr_pkg::req_type     req,
   output smr_pkg::mon_rsp_type mon
);
   import smr_pkg::*;

   localparam int NSLOTS = CPUS * SLOTS_PER_CPU;

   logic [NSLOTS-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff [NSLOTS];
   logic [ADDR_W-1:0] addr_in [NSLOTS];
   logic [RLEN_W-1:0] len_ff [NSLOTS];
   logic [RLEN_W-1:0] len_in [NSLOTS];

   logic [NSLOTS-1:0] mine, match, free_slot, overlap, drop, clr, pick;
   logic [ADDR_W-1:0] aligned;
   logic [EXT_W-1:0]  range_start, range_end;
   logic [LOST_W-1:0] lost;

   assign aligned     = {req.address[ADDR_W-1:3], 3'b000};
   assign range_start = {1'b0, aligned};
   assign range_end   = ({1'b0, req.address} + EXT_W'(access_bytes(req.size_code))
                         + EXT_W'(7)) & ~EXT_W'(7);

   for (genvar i = 0; i < NSLOTS; i++) begin : g_slot
      localparam logic [OWNER_W-1:0] OWNER = OWNER_W'(i / SLOTS_PER_CPU);
      logic [EXT_W-1:0] slot_end;

      assign slot_end     = {1'b0, addr_ff[i]} + EXT_W'(len_ff[i]);
      assign mine[i]      = (OWNER == OWNER_W'(req.cpu));
      assign match[i]     = mine[i] && valid_ff[i] && (addr_ff[i] == aligned);
      assign free_slot[i] = mine[i] && !valid_ff[i];
      assign overlap[i]   = valid_ff[i] && !mine[i]
                            && (range_start < slot_end)
                            && (range_end > {1'b0, addr_ff[i]});
      assign clr[i]       = mine[i] && ((req.address == '0) || match[i]);
   end

   assign drop = write_ok ? overlap : '0;

   // Prefer the slot that already holds this address, else the lowest free one.
   assign pick = (|match) ? (match & (~match + NSLOTS'(1)))
                          : (free_slot & (~free_slot + NSLOTS'(1)));

   // The lost mask is only reported for a successful write, so it is taken
   // from the overlap itself and does not wait on the write decision.
   for (genvar c = 0; c < LOST_W; c++) begin : g_lost
      if (c < CPUS) begin : g_have
         assign lost[c] = |overlap[c*SLOTS_PER_CPU +: SLOTS_PER_CPU];
      end else begin : g_none
         assign lost[c] = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      if (fire) begin
         unique case (req.kind)
            KIND_WRITE: begin
               valid_in = valid_ff & ~drop;
            end
            KIND_SET: begin
               for (int i = 0; i < NSLOTS; i++) begin
                  if (pick[i]) begin
                     valid_in[i] = 1'b1;
                     addr_in[i]  = aligned;
                     len_in[i]   = req.res_size;
                  end
               end
            end
            KIND_CLEAR: begin
               valid_in = valid_ff & ~clr;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      len_ff  <= len_in;
   end

   assign mon.reserved   = |match;
   assign mon.table_full = ~|pick;
   assign mon.lost_mask  = lost;

   a_pick_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick))
      else $error("more than one reservation slot picked");

endmodule

>>> hw/rtl/smp_memory_with_reservation_monitor.sv
// Flow: an accepted request is registered and executed, and its result is registered
//    once the output register is free; while it is held, the next item waits in execute.
// Pacing: a new request is taken only after the previous one has written back, bound
//    by the read-modify-write of the word memory (read at transfer, write-back at commit).
// Reset: synchronous; the word memory is then swept to zero, all MEM_BYTES/8 words
//    (8192 by default), with req ready low; csr writes are taken meanwhile.
module smp_memory_with_reservation_monitor #(
   parameter int MEM_BYTES     = 65536,
   parameter int CPUS          = 4,
   parameter int SLOTS_PER_CPU = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   smr_req_if.sink                      req_bus,
   smr_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [smr_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import smr_pkg::*;

   localparam int WORDS = MEM_BYTES / 8;
   localparam int IW    = $clog2(WORDS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic               state_ff, state_in;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic               accept, out_free, commit, clearing;
   logic [DATA_W-1:0]  mem_rd_data, mem_wr_data;
   logic               mem_wr_en, write_ok;
   mon_rsp_type        mon;

   // A request is taken only between items and once the memory sweep is done.
   // The previous item has already written back by then, so a read issued at
   // the transfer always sees current data and no forwarding is needed.
   assign req_bus.ready = (state_ff == ST_IDLE) && !clearing;
   assign accept        = req_bus.valid && req_bus.ready;

   // The output register may be refilled in the same cycle it is drained.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign commit   = (state_ff == ST_EXEC) && out_free;

   smr_mem #(
      .WORDS (WORDS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_index (req_bus.data.address[IW+2:3]),
      .rd_data  (mem_rd_data),
      .wr_en    (mem_wr_en),
      .wr_index (req_ff.address[IW+2:3]),
      .wr_data  (mem_wr_data),
      .clearing (clearing)
   );

   smr_monitor #(
      .CPUS          (CPUS),
      .SLOTS_PER_CPU (SLOTS_PER_CPU)
   ) u_monitor (
      .clock    (clock),
      .reset    (reset),
      .fire     (commit),
      .write_ok (write_ok),
      .req      (req_ff),
      .mon      (mon)
   );

   // Execute stage: the stored word is available now. Alignment is checked
   // before bounds, and the bounds use the smaller of limit_ff and the size
   // of the memory. The write index is only used once the access is known to
   // lie below that limit, so it always falls inside the array.
   always_comb begin
      logic [3:0]        nbytes;
      logic              misaligned;
      logic              out_of_range;
      logic [EXT_W-1:0]  end_addr;
      logic [EXT_W-1:0]  eff_limit;
      logic [5:0]        shift;
      logic [DATA_W-1:0] value_mask;
      logic [DATA_W-1:0] lane_mask;

      nbytes       = access_bytes(req_ff.size_code);
      misaligned   = |(req_ff.address[2:0] & 3'(nbytes - 4'd1));
      end_addr     = {1'b0, req_ff.address} + EXT_W'(nbytes);
      eff_limit    = (EXT_W'(limit_ff) < EXT_W'(MEM_BYTES)) ? EXT_W'(limit_ff)
                                                            : EXT_W'(MEM_BYTES);
      out_of_range = end_addr > eff_limit;
      shift        = {req_ff.address[2:0], 3'b000};
      value_mask   = (req_ff.size_code == 2'd3) ? '1
                     : ((DATA_W'(1) << {nbytes, 3'b000}) - DATA_W'(1));
      lane_mask    = value_mask << shift;

      mem_wr_data = (mem_rd_data & ~lane_mask)
                    | ((req_ff.write_data & value_mask) << shift);
      write_ok    = 1'b0;
      rsp_in      = '0;

      unique case (req_ff.kind)
         KIND_READ: begin
            if (misaligned) begin
               rsp_in.status = STATUS_ALIGN;
            end else if (out_of_range) begin
               rsp_in.status = STATUS_BADADDR;
            end else begin
               rsp_in.read_data = (mem_rd_data >> shift) & value_mask;
            end
         end
         KIND_WRITE: begin
            if (misaligned) begin
               rsp_in.status = STATUS_ALIGN;
            end else if (out_of_range) begin
               rsp_in.status = STATUS_IGNORED;
            end else begin
               write_ok         = 1'b1;
               rsp_in.lost_mask = mon.lost_mask;
            end
         end
         KIND_SET: begin
            if (mon.table_full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         KIND_QUERY: begin
            rsp_in.reserved = mon.reserved;
         end
         default: begin
            // Clears answer all zero, and so do the unused kinds.
         end
      endcase
   end

   assign mem_wr_en = commit && write_ok;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_bus.data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execution");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_EXEC) && !clearing)
      else $error("memory written outside execution");

   a_lost_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.data.lost_mask != '0))
      |-> (rsp_bus.data.status == STATUS_OK))
      else $error("lost reservations reported on a failed request");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !accept)
      else $error("request taken during the memory sweep");

endmodule

>>> bench/smp_memory_with_reservation_monitor_test.sv
`timescale 1ns / 1ps

module smp_memory_with_reservation_monitor_test;
   import smr_pkg::*;

   localparam int MEM_BYTES     = 65536;
   localparam int CPUS          = 4;
   localparam int SLOTS_PER_CPU = 2;
   localparam int WORDS         = MEM_BYTES / 8;
   localparam int SLOTS         = CPUS * SLOTS_PER_CPU;

   // The slowest passing run covers the reset sweep, about 430 requests plus sender gaps
   // and receiver stalls, and one long receiver hold; the limit leaves a wide margin.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int LONG_HOLD    = 400;

   // Kind codes from this value up have no function and answer all zeros.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd5;
   localparam logic [63:0]       WORD_ALIGN  = ~64'h7;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   smr_req_if req_bus ();
   smr_rsp_if rsp_bus ();

   smp_memory_with_reservation_monitor #(
      .MEM_BYTES     (MEM_BYTES),
      .CPUS          (CPUS),
      .SLOTS_PER_CPU (SLOTS_PER_CPU)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the memory, the reservation table and the limit register.
   // It is updated at the clock edge on which a request transfer is accepted.
   logic [DATA_W-1:0]  mem_image  [WORDS];
   logic               resv_valid [SLOTS];
   logic [ADDR_W-1:0]  resv_base  [SLOTS];
   logic [RLEN_W-1:0]  resv_len   [SLOTS];
   logic [LIMIT_W-1:0] limit_shadow;

   // Answers owed by the block, oldest first.
   rsp_type owed_answers [$];

   int mismatches;
   int cycles_run;
   int hold_request;    // nonzero asks the receiver for a stall whose length it gives
   bit sender_gaps_on;
   int burst_left;
   bit offering;        // request valid is currently driven high

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The bounds check uses the smaller of the register and the memory size.
   function automatic int usable_bytes();
      return (limit_shadow < MEM_BYTES) ? int'(limit_shadow) : MEM_BYTES;
   endfunction

   function automatic void drop_slot(input int slot);
      resv_valid[slot] = 1'b0;
      resv_base[slot]  = '0;
      resv_len[slot]   = '0;
   endfunction

   // Applies one request to the shadow state and returns the answer it must produce.
   function automatic rsp_type shadow_apply(input req_type r);
      rsp_type     a;
      logic [63:0] addr, nbytes, aligned, lanes, span_lo, span_hi;
      int          word, shift, first, hit, spare;
      a       = '0;
      addr    = 64'(r.address);
      nbytes  = 64'd1 << r.size_code;
      aligned = addr & WORD_ALIGN;
      first   = int'(r.cpu) * SLOTS_PER_CPU;
      case (r.kind)
         KIND_READ, KIND_WRITE: begin
            // Alignment is judged before the bounds, and a fault touches nothing.
            if ((addr & (nbytes - 1)) != 0) begin
               a.status = STATUS_ALIGN;
            end else if (addr + nbytes > 64'(usable_bytes())) begin
               a.status = (r.kind == KIND_READ) ? STATUS_BADADDR : STATUS_IGNORED;
            end else begin
               word  = int'(addr >> 3);
               shift = int'(addr[2:0]) * 8;
               lanes = (nbytes == 8) ? '1 : (64'd1 << (nbytes * 8)) - 1;
               if (r.kind == KIND_READ) begin
                  a.read_data = (mem_image[word] >> shift) & lanes;
               end else begin
                  mem_image[word] = (mem_image[word] & ~(lanes << shift))
                                    | ((r.write_data & lanes) << shift);
                  // Other processors lose any reservation that overlaps the write
                  // range widened to whole words; an empty reservation never overlaps.
                  span_lo = aligned;
                  span_hi = (addr + nbytes + 7) & WORD_ALIGN;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (i / SLOTS_PER_CPU != int'(r.cpu) && resv_valid[i]
                         && span_lo < 64'(resv_base[i]) + 64'(resv_len[i])
                         && span_hi > 64'(resv_base[i])) begin
                        drop_slot(i);
                        a.lost_mask[i / SLOTS_PER_CPU] = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_SET: begin
            // A slot already on this word is refreshed; else the lowest free one is taken.
            hit   = -1;
            spare = -1;
            for (int i = first; i < first + SLOTS_PER_CPU; i++) begin
               if (resv_valid[i] && resv_base[i] == aligned[ADDR_W-1:0] && hit < 0)
                  hit = i;
               if (!resv_valid[i] && spare < 0)
                  spare = i;
            end
            if (hit < 0)
               hit = spare;
            if (hit < 0) begin
               a.status = STATUS_FULL;
            end else begin
               resv_valid[hit] = 1'b1;
               resv_base[hit]  = aligned[ADDR_W-1:0];
               resv_len[hit]   = r.res_size;
            end
         end
         KIND_CLEAR: begin
            // Address zero wipes every slot of the processor.
            for (int i = first; i < first + SLOTS_PER_CPU; i++)
               if (addr == 0 || (resv_valid[i] && resv_base[i] == aligned[ADDR_W-1:0]))
                  drop_slot(i);
         end
         KIND_QUERY: begin
            for (int i = first; i < first + SLOTS_PER_CPU; i++)
               if (resv_valid[i] && resv_base[i] == aligned[ADDR_W-1:0])
                  a.reserved = 1'b1;
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   function automatic req_type request_of(input logic [KIND_W-1:0] kind,
                                          input int unsigned       cpu,
                                          input logic [ADDR_W-1:0] addr,
                                          input int unsigned       size_code,
                                          input logic [DATA_W-1:0] wdata,
                                          input int unsigned       rlen);
      req_type r;
      r            = '0;
      r.kind       = kind;
      r.cpu        = CPU_W'(cpu);
      r.address    = addr;
      r.size_code  = SIZE_W'(size_code);
      r.write_data = wdata;
      r.res_size   = RLEN_W'(rlen);
      return r;
   endfunction

   // Mostly a small window where reservations collide, sometimes the edge of the
   // limit, sometimes anywhere in the address space. Most picks are aligned.
   function automatic logic [ADDR_W-1:0] pick_address(input int unsigned bytes);
      logic [63:0] a;
      int          near;
      case ($urandom_range(0, 9))
         8: a = {$urandom, $urandom};
         6, 7: begin
            near = usable_bytes() + int'($urandom_range(0, 24)) - 16;
            if (near < 0)
               near = 0;
            a = 64'(near);
         end
         default: a = 64'($urandom_range(0, 575));
      endcase
      if ($urandom_range(0, 7) != 0)
         a = a & ~64'(bytes - 1);
      return a[ADDR_W-1:0];
   endfunction

   // Reservation lengths: mostly within one line, some empty, some above 64.
   function automatic int unsigned pick_length();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return $urandom_range(65, 127);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r            = '0;
      r.cpu        = CPU_W'($urandom_range(0, CPUS - 1));
      r.size_code  = SIZE_W'($urandom_range(0, 3));
      r.write_data = {$urandom, $urandom};
      r.res_size   = RLEN_W'(pick_length());
      r.address    = pick_address(1 << r.size_code);
      pick         = $urandom_range(0, 19);
      if (pick < 7)
         r.kind = KIND_READ;
      else if (pick < 14)
         r.kind = KIND_WRITE;
      else if (pick < 16)
         r.kind = KIND_SET;
      else if (pick < 17)
         r.kind = KIND_CLEAR;
      else if (pick < 18)
         r.kind = KIND_QUERY;
      else if (pick < 19)
         r.kind = KIND_W'($urandom_range(KIND_UNUSED, {KIND_W{1'b1}}));
      else begin
         // Pure noise: every field at random over its full width.
         r.kind    = KIND_W'($urandom_range(0, {KIND_W{1'b1}}));
         r.address = ADDR_W'({$urandom, $urandom});
      end
      if (r.kind == KIND_CLEAR && $urandom_range(0, 3) == 0)
         r.address = '0;
      return r;
   endfunction

   // Offers one request and waits for its transfer. The expected answer is worked
   // out at the accepting edge. Valid stays high into the next request unless a
   // gap between bursts follows, so it is never lowered and raised in one step.
   task automatic send_request(input req_type item);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      offering = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      owed_answers.push_back(shadow_apply(item));
      if (sender_gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
            gap = $urandom_range(1, 8);
            req_bus.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering and waits until every owed answer has come back.
   task automatic settle();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      while (owed_answers.size() != 0)
         @(posedge clock);
   endtask

   // The limit register is only written with the block idle.
   task automatic program_limit(input logic [LIMIT_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_shadow = value;
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_mixed_traffic(input int count);
      repeat (count)
         send_request(random_request());
   endtask

   // Widths, byte lanes, alignment faults and both sides of the limit.
   task automatic test_directed_access();
      program_limit(LIMIT_RESET);
      send_request(request_of(KIND_WRITE, 0, 0, 3, 64'h0123_4567_89AB_CDEF, 0));
      send_request(request_of(KIND_READ, 1, 0, 3, '0, 0));
      // A narrow write uses only the low bytes of the data.
      send_request(request_of(KIND_WRITE, 2, 7, 0, 64'hFFFF_FFFF_FFFF_FF5A, 0));
      send_request(request_of(KIND_READ, 3, 6, 1, '0, 0));
      send_request(request_of(KIND_WRITE, 1, 12, 2, 64'hDEAD_BEEF_CAFE_F00D, 0));
      send_request(request_of(KIND_READ, 0, 8, 3, '0, 0));
      send_request(request_of(KIND_READ, 0, 1, 1, '0, 0));
      send_request(request_of(KIND_WRITE, 2, 4, 3, '1, 0));
      // The last word below the limit is usable, the first beyond is not.
      send_request(request_of(KIND_WRITE, 3, ADDR_W'(MEM_BYTES - 8), 3, '1, 0));
      send_request(request_of(KIND_READ, 3, ADDR_W'(MEM_BYTES - 8), 3, '0, 0));
      send_request(request_of(KIND_READ, 1, ADDR_W'(MEM_BYTES), 3, '0, 0));
      send_request(request_of(KIND_WRITE, 2, ADDR_W'(MEM_BYTES), 2, '1, 0));
      send_request(request_of(KIND_READ, 0, {ADDR_W{1'b1}} & WORD_ALIGN[ADDR_W-1:0],
                              3, '0, 0));
   endtask

   // In-place update, a full table, empty slots, a lost reservation and both clears.
   task automatic test_directed_reservations();
      send_request(request_of(KIND_SET, 1, 'h20, 0, '0, 8));
      send_request(request_of(KIND_SET, 1, 'h25, 0, '0, 64));
      send_request(request_of(KIND_SET, 1, 'h100, 0, '0, 0));
      send_request(request_of(KIND_SET, 1, 'h200, 0, '0, 8));
      send_request(request_of(KIND_QUERY, 1, 'h27, 0, '0, 0));
      // Next to the empty slot nothing is lost; inside the top of the first one it is lost.
      send_request(request_of(KIND_WRITE, 0, 'h108, 0, '1, 0));
      send_request(request_of(KIND_WRITE, 2, 'h5E, 1, 64'h1234, 0));
      send_request(request_of(KIND_SET, 3, 'h40, 0, '0, 127));
      send_request(request_of(KIND_CLEAR, 3, 'h41, 0, '0, 0));
      send_request(request_of(KIND_SET, 2, 'h48, 0, '0, 8));
      send_request(request_of(KIND_CLEAR, 2, 0, 0, '0, 0));
      send_request(request_of(KIND_QUERY, 2, 'h48, 0, '0, 0));
      send_request(request_of(KIND_UNUSED, 3, 'h48, 3, '1, 127));
   endtask

   // A one-word limit, a register above the memory size, an odd limit and a random one.
   task automatic test_limit_extremes();
      logic [LIMIT_W-1:0] some_limit;
      program_limit(LIMIT_W'(8));
      send_mixed_traffic(30);
      program_limit({LIMIT_W{1'b1}});
      send_mixed_traffic(30);
      program_limit(LIMIT_W'(MEM_BYTES - 1));
      send_mixed_traffic(30);
      some_limit = LIMIT_W'($urandom_range(8, MEM_BYTES));
      program_limit(some_limit);
      send_mixed_traffic(30);
      program_limit(LIMIT_RESET);
   endtask

   // One processor takes a reservation and the others work around it: the usual
   // load-locked pattern with random contents.
   task automatic test_contended_reservations();
      int unsigned       holder, other, sz;
      int                probe;
      logic [ADDR_W-1:0] spot;
      repeat (40) begin
         holder = $urandom_range(0, CPUS - 1);
         spot   = ADDR_W'($urandom_range(0, 63)) << 3;
         send_request(request_of(KIND_SET, holder, spot | ADDR_W'($urandom_range(0, 7)),
                                 $urandom_range(0, 3), {$urandom, $urandom},
                                 pick_length()));
         repeat ($urandom_range(2, 5)) begin
            other = (holder + $urandom_range(1, CPUS - 1)) % CPUS;
            sz    = $urandom_range(0, 3);
            probe = int'(spot) + int'($urandom_range(0, 80)) - 16;
            if (probe < 0)
               probe = 0;
            if ($urandom_range(0, 7) != 0)
               probe = probe & ~((1 << sz) - 1);
            case ($urandom_range(0, 7))
               0, 1, 2: send_request(request_of(KIND_WRITE, other, ADDR_W'(probe), sz,
                                                {$urandom, $urandom}, 0));
               3: send_request(request_of(KIND_READ, other, ADDR_W'(probe), sz, '0, 0));
               4: send_request(request_of(KIND_QUERY, holder,
                                          spot | ADDR_W'($urandom_range(0, 7)), sz, '0, 0));
               5: send_request(request_of(KIND_WRITE, holder, ADDR_W'(probe), sz,
                                          {$urandom, $urandom}, 0));
               6: send_request(request_of(KIND_CLEAR, holder,
                                          ($urandom_range(0, 3) == 0) ? '0 : spot, 0, '0, 0));
               default: send_request(request_of(KIND_SET, other, ADDR_W'(probe), sz, '0,
                                                pick_length()));
            endcase
         end
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming
   // back to back, so the block fills up and stops taking transfers.
   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      hold_request   = LONG_HOLD;
      send_mixed_traffic(40);
      sender_gaps_on = 1'b1;
      settle();
   endtask

   task automatic test_random_mix();
      send_mixed_traffic(60);
   endtask

   // Receiver: runs and stalls of random length, with some long stall-free
   // stretches, unless a long hold has been asked for.
   initial begin : response_pacing
      int stall_left;
      int run_left;
      stall_left    = 0;
      run_left      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            run_left     = 0;
            hold_request = 0;
         end else if (stall_left == 0 && run_left == 0) begin
            run_left   = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 10);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (run_left > 0)
               run_left--;
         end
      end
   end

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // Every result transfer is matched against the oldest owed answer.
   always @(posedge clock) begin : answer_check
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result transfer with no request outstanding", $time);
         end else begin
            want = owed_answers.pop_front();
            compare_field("read_data", want.read_data, rsp_bus.data.read_data);
            compare_field("status", 64'(want.status), 64'(rsp_bus.data.status));
            compare_field("reserved", 64'(want.reserved), 64'(rsp_bus.data.reserved));
            compare_field("lost_mask", 64'(want.lost_mask), 64'(rsp_bus.data.lost_mask));
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin : watchdog
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      limit_shadow  = LIMIT_RESET;
      foreach (mem_image[w])
         mem_image[w] = '0;
      foreach (resv_valid[s])
         drop_slot(s);
      mismatches     = 0;
      hold_request   = 0;
      sender_gaps_on = 1'b1;
      burst_left     = 0;
      offering       = 1'b0;

      // The block clears its memory after reset; the first request transfer
      // simply waits for ready.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_access();
      test_directed_reservations();
      test_limit_extremes();
      test_contended_reservations();
      test_backpressure();
      test_random_mix();

      // Drain, then give the pipeline time to show any stray result.
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && owed_answers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/smr_pkg.sv
hw/rtl/smr_if.sv
hw/rtl/smr_mem.sv
hw/rtl/smr_monitor.sv
hw/rtl/smp_memory_with_reservation_monitor.sv
bench/smp_memory_with_reservation_monitor_test.sv
